// ----- rtl/core/gb3_pkg.sv -----
package gb3_pkg;

    // Parameter defaults
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_PIXEL_BITS = 16;

    // Port field widths
    localparam int PIX_W   = 16;
    localparam int WREG_W  = 11;
    localparam int HREG_W  = 12;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [WREG_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [HREG_W-1:0] IMAGE_HEIGHT_RST = 12'd768;

    // Input kinds on tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Output queue
    localparam int MAX_RESULTS = 2;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = 3;
    localparam int OUT_CNT_W   = 4;

    // Kernel sum: 16x the largest pixel fits in four extra bits
    localparam int BLUR_SUM_W = PIX_W + 4;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
    } t_out_entry;

    // 1 2 1 / 2 4 2 / 1 2 1 kernel, rounded and divided by 16
    function automatic logic [PIX_W-1:0] blur3(
        input logic [PIX_W-1:0] t0, input logic [PIX_W-1:0] t1, input logic [PIX_W-1:0] t2,
        input logic [PIX_W-1:0] m0, input logic [PIX_W-1:0] m1, input logic [PIX_W-1:0] m2,
        input logic [PIX_W-1:0] b0, input logic [PIX_W-1:0] b1, input logic [PIX_W-1:0] b2
    );
        logic [BLUR_SUM_W-1:0] sum;
        sum = BLUR_SUM_W'(t0) + (BLUR_SUM_W'(t1) << 1) + BLUR_SUM_W'(t2)
            + (BLUR_SUM_W'(m0) << 1) + (BLUR_SUM_W'(m1) << 2) + (BLUR_SUM_W'(m2) << 1)
            + BLUR_SUM_W'(b0) + (BLUR_SUM_W'(b1) << 1) + BLUR_SUM_W'(b2)
            + BLUR_SUM_W'(8);
        return sum[BLUR_SUM_W-1:4];
    endfunction

endpackage

// ----- rtl/core/gaussian_blur_3x3_stream.sv -----
// 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1, rounded, over 16) on a raster pixel stream,
// edge pixels repeated on all four borders.
// Input channel (s_*): tdata = pixel, tuser = kind (pixel or drain). Pixels come in
// raster order; the results of row r are produced while row r+1 arrives (none for
// the first pixel of a row, two for the last one). Once the whole frame is in, each
// drain item yields one pixel of the last row; tlast marks the final pixel of the frame.
// Pixels sent while a drain is pending and drains with nothing pending are consumed
// without result.
// Output channel (m_*): tdata = blurred pixel, tlast = end of frame.
// Config port: width (index 0) and height (index 1); a write restarts the frame.
// Throughput: one item per clock while s_tready is high. The line buffers are read into
// the stage 1 registers when an item is accepted; the kernel works from these and writes
// its results into the output queue. The line buffers are two single-port-read,
// single-port-write RAMs of MAX_WIDTH pixels each, read once per accepted item and written back once per frame pixel.
// An 8-entry output queue decouples the receiver: when it stalls, s_tready falls
// once fewer than four queue entries are free and rises as results drain.
// Reset clears the counters, the pipeline and the queue and loads the default
// 1024 x 768 frame size; line buffers are not cleared (every row 0 writes them first).
module gaussian_blur_3x3_stream
    import gb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PIX_W-1:0]     i_s_tdata,   // [15:0] pixel_in
    input  logic                 i_s_tuser,   // [0] command
    // output stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [PIX_W-1:0]     o_m_tdata,   // [15:0] pixel_out
    output logic                 o_m_tlast,   // frame_last
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = ((AW > WREG_W) ? AW : WREG_W) + 1;

    typedef struct packed {
        logic                  drain;
        logic [AW-1:0]         addr;
        logic [PIXEL_BITS-1:0] px;
        logic                  row0;
        logic                  first;
        logic                  gen_mid;
        logic                  gen_end;
        logic                  last;
        logic                  has_right;
    } t_s1;

    // Config registers
    logic [WREG_W-1:0] r_image_width;
    logic [HREG_W-1:0] r_image_height;
    logic              cfg_hit;

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == REG_IMAGE_WIDTH || i_cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WREG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HREG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size
    logic [WREG_W-1:0] w_eff;
    logic [HREG_W-1:0] h_eff;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WREG_W'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_eff = WREG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
        h_eff = (r_image_height == '0) ? HREG_W'(1) : r_image_height;
    end

    // Stage 0: accept, counters, line buffer read address
    logic [AW-1:0]     r_col;
    logic [HREG_W-1:0] r_row;
    logic [AW-1:0]     r_drain;
    logic              s_acc;
    logic              is_drain;
    logic              frame_in;
    logic              go_pix;
    logic              go_drain;
    logic              col_last;
    logic              drain_last;
    logic [AW-1:0]     rd_addr;
    logic [OUT_CNT_W-1:0] r_count;

    assign o_s_tready = r_count <= OUT_CNT_W'(OUT_DEPTH - 2 * MAX_RESULTS);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign is_drain   = i_s_tuser == CMD_DRAIN;
    assign frame_in   = r_row >= h_eff;
    assign go_pix     = s_acc && !is_drain && !frame_in;
    assign go_drain   = s_acc && is_drain && frame_in;
    assign col_last   = (CW'(r_col) + CW'(1)) == CW'(w_eff);
    assign drain_last = (CW'(r_drain) + CW'(1)) == CW'(w_eff);

    always_comb begin
        if (is_drain) begin
            rd_addr = drain_last ? r_drain : r_drain + AW'(1);
        end else begin
            rd_addr = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (cfg_hit) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (go_pix) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= r_row + HREG_W'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end else if (go_drain) begin
            if (drain_last) begin
                r_drain <= '0;
                r_row   <= '0;
                r_col   <= '0;
            end else begin
                r_drain <= r_drain + AW'(1);
            end
        end
    end

    // Stage 1 item register
    logic r_s1_valid;
    t_s1  r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= go_pix || go_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1.drain     <= is_drain;
            r_s1.addr      <= rd_addr;
            r_s1.px        <= i_s_tdata[PIXEL_BITS-1:0];
            r_s1.row0      <= r_row == '0;
            r_s1.first     <= is_drain ? (r_drain == '0) : (r_col == '0);
            r_s1.gen_mid   <= (r_col != '0) && (r_row != '0);
            r_s1.gen_end   <= col_last && (r_row != '0);
            r_s1.last      <= drain_last;
            r_s1.has_right <= !drain_last;
        end
    end

    // Line buffers with write-to-read forwarding
    logic [PIXEL_BITS-1:0] r_mem_above [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_mem_cur   [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd_above;
    logic [PIXEL_BITS-1:0] r_rd_cur;
    logic                  r_fwd;
    logic [PIXEL_BITS-1:0] r_fwd_above;
    logic [PIXEL_BITS-1:0] r_fwd_cur;
    logic                  wr_en;
    logic [PIXEL_BITS-1:0] wr_above;

    assign wr_en = r_s1_valid && !r_s1.drain;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_above[r_s1.addr] <= wr_above;
            r_mem_cur[r_s1.addr]   <= r_s1.px;
        end
        if (s_acc) begin
            r_rd_above <= r_mem_above[rd_addr];
            r_rd_cur   <= r_mem_cur[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (s_acc) begin
            r_fwd <= wr_en && (r_s1.addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_fwd_above <= wr_above;
            r_fwd_cur   <= r_s1.px;
        end
    end

    // Stage 1: kernel, window update, write-back data
    logic [PIXEL_BITS-1:0] rd_a, rd_c;
    logic [PIXEL_BITS-1:0] top, mid;
    logic [PIXEL_BITS-1:0] left_t, left_m, left_b;
    logic [PIXEL_BITS-1:0] r_wa_t, r_wa_m, r_wa_b;  // older window column
    logic [PIXEL_BITS-1:0] r_wb_t, r_wb_m, r_wb_b;  // newer window column
    logic [PIXEL_BITS-1:0] r_c0_a, r_c0_c;          // column 0 of both line buffers
    logic [PIXEL_BITS-1:0] r_dl_a, r_dl_c;          // drain: entry left of current
    logic [PIXEL_BITS-1:0] r_dd_a, r_dd_c;          // drain: current entry
    logic [PIXEL_BITS-1:0] dl_a, dl_c, dd_a, dd_c, dr_a, dr_c;
    logic [PIX_W-1:0]      mid_res, end_res, drain_res;

    always_comb begin
        rd_a = r_fwd ? r_fwd_above : r_rd_above;
        rd_c = r_fwd ? r_fwd_cur : r_rd_cur;
        top  = r_s1.row0 ? r_s1.px : rd_a;
        mid  = r_s1.row0 ? r_s1.px : rd_c;
        wr_above = mid;
        if (r_s1.first) begin
            left_t = top;
            left_m = mid;
            left_b = r_s1.px;
        end else begin
            left_t = r_wb_t;
            left_m = r_wb_m;
            left_b = r_wb_b;
        end
        mid_res = blur3(PIX_W'(r_wa_t), PIX_W'(r_wb_t), PIX_W'(top),
                        PIX_W'(r_wa_m), PIX_W'(r_wb_m), PIX_W'(mid),
                        PIX_W'(r_wa_b), PIX_W'(r_wb_b), PIX_W'(r_s1.px));
        end_res = blur3(PIX_W'(left_t), PIX_W'(top), PIX_W'(top),
                        PIX_W'(left_m), PIX_W'(mid), PIX_W'(mid),
                        PIX_W'(left_b), PIX_W'(r_s1.px), PIX_W'(r_s1.px));
        // drain: last row below edge repeats the current row
        dl_a = r_s1.first ? r_c0_a : r_dl_a;
        dl_c = r_s1.first ? r_c0_c : r_dl_c;
        dd_a = r_s1.first ? r_c0_a : r_dd_a;
        dd_c = r_s1.first ? r_c0_c : r_dd_c;
        dr_a = r_s1.has_right ? rd_a : dd_a;
        dr_c = r_s1.has_right ? rd_c : dd_c;
        drain_res = blur3(PIX_W'(dl_a), PIX_W'(dd_a), PIX_W'(dr_a),
                          PIX_W'(dl_c), PIX_W'(dd_c), PIX_W'(dr_c),
                          PIX_W'(dl_c), PIX_W'(dd_c), PIX_W'(dr_c));
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            if (r_s1.drain) begin
                r_dl_a <= dd_a;
                r_dl_c <= dd_c;
                r_dd_a <= dr_a;
                r_dd_c <= dr_c;
            end else begin
                r_wa_t <= left_t;
                r_wa_m <= left_m;
                r_wa_b <= left_b;
                r_wb_t <= top;
                r_wb_m <= mid;
                r_wb_b <= r_s1.px;
                if (r_s1.first) begin
                    r_c0_a <= mid;
                    r_c0_c <= r_s1.px;
                end
            end
        end
    end

    // Output queue: up to two pushes, one pop per cycle
    t_out_entry           r_fifo [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    t_out_entry           push0, push1;
    logic [1:0]           n_push;
    logic                 pop;

    always_comb begin
        push1.last = 1'b0;
        push1.pix  = end_res;
        if (r_s1.drain) begin
            push0.last = r_s1.last;
            push0.pix  = drain_res;
            n_push     = 2'd1;
        end else begin
            push0.last = 1'b0;
            push0.pix  = r_s1.gen_mid ? mid_res : end_res;
            n_push     = 2'(r_s1.gen_mid) + 2'(r_s1.gen_end);
        end
        if (!r_s1_valid) begin
            n_push = 2'd0;
        end
    end

    assign pop        = o_m_tvalid && i_m_tready;
    assign o_m_tvalid = r_count != '0;
    assign o_m_tdata  = r_fifo[r_rd_ptr].pix;
    assign o_m_tlast  = r_fifo[r_rd_ptr].last;

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= push0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr_ptr + OUT_PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(n_push);
            r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(pop);
            r_count  <= r_count + OUT_CNT_W'(n_push) - OUT_CNT_W'(pop);
        end
    end

endmodule

// ----- rtl/core/gb3_stream_chk.sv -----
module gb3_stream_chk
    import gb3_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [PIX_W-1:0] o_m_tdata,
    input logic             o_m_tlast
);

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    // Stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    // Stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // No result appears on an empty output unless an item was accepted and passed through the stage 1 register
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && !s_acc && !$past(s_acc) |=> !o_m_tvalid)
        else $error("result without a causing item");

endmodule

bind gaussian_blur_3x3_stream gb3_stream_chk u_gb3_stream_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
